@@ rtl/ptcp_pkg.sv @@
`timescale 1ns / 1ps
package ptcp_pkg;

	localparam int CW    = 32;
	localparam int NIN   = 12;
	localparam int NOUT  = 4;
	localparam int DXW   = CW + 1;
	localparam int PRW   = 2 * DXW;
	localparam int AW    = PRW + 2;
	localparam int HW    = AW + 1;
	localparam int SPW   = AW + 2;
	localparam int PW    = 2 * AW;
	localparam int SW    = PW + 1;
	localparam int DW    = SW + 3;
	localparam int FRAC  = 16;
	localparam int QW    = FRAC + 1;
	localparam int OW    = DXW + QW + 1;
	localparam int FW    = OW + 1;
	localparam int CXW   = FW - FRAC + 1;
	localparam int SQW   = 2 * DXW + 1;
	localparam int RW    = 2 * CW;
	localparam int ROOTW = CW;

	localparam logic [QW-1:0]        ONE_Q     = QW'(1) << FRAC;
	localparam logic signed [FW-1:0] ROUND_HALF = FW'(1) << (FRAC - 1);
	localparam logic signed [CW-1:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [CW-1:0] COORD_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		SEL_ZERO   = 3'd0,
		SEL_ONE    = 3'd1,
		SEL_QA     = 3'd2,
		SEL_QB     = 3'd3,
		SEL_INV_QA = 3'd4
	} sel_t;

endpackage

@@ rtl/ptcp_dly.sv @@
`timescale 1ns / 1ps
module ptcp_dly #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= din;
			for (int i = 1; i < N; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign dout = tap_s[N-1];

endmodule

@@ rtl/ptcp_wmul.sv @@
`timescale 1ns / 1ps
module ptcp_wmul import ptcp_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] x,
	input  logic signed [AW-1:0] y,
	output logic signed [PW-1:0] p
);

	localparam int NCH = 4;
	localparam int CHW = AW / NCH;
	localparam int XH  = AW / 2;

	logic signed [AW-1:0] x_s   [NCH-1];
	logic signed [AW-1:0] y_s   [NCH-1];
	logic signed [PW-1:0] acc_s [NCH];

	for (genvar k = 0; k < NCH; k++) begin : g_row
		logic signed [AW-1:0]        xin;
		logic signed [AW-1:0]        yin;
		logic signed [PW-1:0]        prev;
		logic signed [CHW:0]         ch;
		logic signed [XH:0]          xl;
		logic signed [AW-XH-1:0]     xh;
		logic signed [XH+CHW+1:0]    pl;
		logic signed [AW-XH+CHW:0]   ph;

		if (k == 0) begin : g_first
			assign xin  = x;
			assign yin  = y;
			assign prev = '0;
		end else begin : g_next
			assign xin  = x_s[k-1];
			assign yin  = y_s[k-1];
			assign prev = acc_s[k-1];
		end

		if (k == NCH - 1) begin : g_top
			assign ch = {yin[AW-1], yin[AW-1 -: CHW]};
		end else begin : g_low
			assign ch = {1'b0, yin[k*CHW +: CHW]};
		end

		// The low half of x is unsigned and the high half carries the sign.
		assign xl = {1'b0, xin[XH-1:0]};
		assign xh = xin[AW-1:XH];
		assign pl = xl * ch;
		assign ph = xh * ch;

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[k] <= prev + (PW'(pl) <<< (k * CHW)) + (PW'(ph) <<< (k * CHW + XH));
			end
		end

		if (k < NCH - 1) begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					x_s[k] <= xin;
					y_s[k] <= yin;
				end
			end
		end
	end

	assign p = acc_s[NCH-1];

endmodule

@@ rtl/ptcp_div.sv @@
`timescale 1ns / 1ps
module ptcp_div import ptcp_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [DW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic [QW-1:0]        q
);

	localparam int NIT = FRAC;

	logic [DW-1:0]   rem_s  [NIT];
	logic [DW-1:0]   den_s  [NIT+1];
	logic [FRAC-1:0] bits_s [NIT+1];
	logic            one_s  [NIT+1];
	logic            zero_s [NIT+1];

	always_ff @(posedge clk) begin
		if (en) begin
			one_s[0]  <= !(den <= 0) && (num >= den);
			zero_s[0] <= (den <= 0) || (!(num >= den) && (num <= 0));
			rem_s[0]  <= num;
			den_s[0]  <= den;
			bits_s[0] <= '0;
		end
	end

	for (genvar j = 1; j <= NIT; j++) begin : g_it
		logic [DW:0] r2;
		logic        ge;

		assign r2 = {rem_s[j-1], 1'b0};
		assign ge = r2 >= {1'b0, den_s[j-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j]  <= den_s[j-1];
				bits_s[j] <= {bits_s[j-1][FRAC-2:0], ge};
				one_s[j]  <= one_s[j-1];
				zero_s[j] <= zero_s[j-1];
			end
		end

		if (j < NIT) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= ge ? DW'(r2 - {1'b0, den_s[j-1]}) : DW'(r2);
				end
			end
		end
	end

	always_comb begin
		if (one_s[NIT]) begin
			q = ONE_Q;
		end else if (zero_s[NIT]) begin
			q = '0;
		end else begin
			q = {1'b0, bits_s[NIT]};
		end
	end

endmodule

@@ rtl/ptcp_isqrt.sv @@
`timescale 1ns / 1ps
module ptcp_isqrt import ptcp_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [RW-1:0]    n,
	output logic [ROOTW-1:0] root
);

	localparam int NST = RW / 2;

	logic [RW-1:0] n_s [NST-1];
	logic [RW-1:0] r_s [NST];

	for (genvar j = 0; j < NST; j++) begin : g_st
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (NST - 1 - j));
		logic [RW-1:0] nin;
		logic [RW-1:0] rin;
		logic [RW-1:0] trial;
		logic          ge;

		if (j == 0) begin : g_first
			assign nin = n;
			assign rin = '0;
		end else begin : g_next
			assign nin = n_s[j-1];
			assign rin = r_s[j-1];
		end

		assign trial = rin + BIT;
		assign ge    = nin >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[j] <= ge ? (rin >> 1) + BIT : rin >> 1;
			end
		end

		if (j < NST - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					n_s[j] <= ge ? nin - trial : nin;
				end
			end
		end
	end

	assign root = r_s[NST-1][ROOTW-1:0];

endmodule

@@ rtl/point_triangle_closest_point.sv @@
`timescale 1ns / 1ps
// Throughput is one beat per cycle; the whole pipeline advances together and
// holds when the output beat is not taken.
// The pipeline holds the two 16-step divider pipelines and the 32-step square root.
// Reset clears only the valid bits; no result is pending after reset.
module point_triangle_closest_point import ptcp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, query_x, query_y, query_z
	input  logic [NIN*CW-1:0]     s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// closest_x, closest_y, closest_z, separation
	output logic [NOUT*CW-1:0]    m_tdata
);

	localparam int LAT      = 66;
	localparam int DLY_SIDE = 27;
	localparam int DLY_DOT  = 5;
	localparam int DLY_SEL  = 17;
	localparam int DLY_CL   = 34;
	localparam int DLY_OV   = 32;
	localparam int SIDEW    = 2 * CW + 2 * DXW;
	localparam int DOTW     = 5 * AW + SPW;
	localparam int SELW     = 6;

	logic en;
	logic vld_q [LAT];

	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= s_tvalid;
			for (int i = 1; i < LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	logic signed [CW-1:0] vin [NIN];

	always_comb begin
		for (int k = 0; k < NIN; k++) begin
			vin[k] = s_tdata[CW*k +: CW];
		end
	end

	logic signed [DXW-1:0] eu_s1 [3];
	logic signed [DXW-1:0] ew_s1 [3];
	logic signed [DXW-1:0] g_s1  [3];
	logic signed [CW-1:0]  v0_s1 [3];
	logic signed [CW-1:0]  qp_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				eu_s1[i] <= DXW'(vin[3+i]) - DXW'(vin[i]);
				ew_s1[i] <= DXW'(vin[6+i]) - DXW'(vin[i]);
				g_s1[i]  <= DXW'(vin[i]) - DXW'(vin[9+i]);
				v0_s1[i] <= vin[i];
				qp_s1[i] <= vin[9+i];
			end
		end
	end

	logic signed [PRW-1:0] uu_s2 [3];
	logic signed [PRW-1:0] uw_s2 [3];
	logic signed [PRW-1:0] ww_s2 [3];
	logic signed [PRW-1:0] ug_s2 [3];
	logic signed [PRW-1:0] wg_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				uu_s2[i] <= eu_s1[i] * eu_s1[i];
				uw_s2[i] <= eu_s1[i] * ew_s1[i];
				ww_s2[i] <= ew_s1[i] * ew_s1[i];
				ug_s2[i] <= eu_s1[i] * g_s1[i];
				wg_s2[i] <= ew_s1[i] * g_s1[i];
			end
		end
	end

	logic signed [AW-1:0]  a_c, b_c, c_c, d_c, e_c;
	logic signed [SPW-1:0] span_c;
	logic signed [AW-1:0]  a_s3, b_s3, c_s3, d_s3, e_s3;
	logic signed [SPW-1:0] span_s3;

	always_comb begin
		a_c    = AW'(uu_s2[0]) + AW'(uu_s2[1]) + AW'(uu_s2[2]);
		b_c    = AW'(uw_s2[0]) + AW'(uw_s2[1]) + AW'(uw_s2[2]);
		c_c    = AW'(ww_s2[0]) + AW'(ww_s2[1]) + AW'(ww_s2[2]);
		d_c    = AW'(ug_s2[0]) + AW'(ug_s2[1]) + AW'(ug_s2[2]);
		e_c    = AW'(wg_s2[0]) + AW'(wg_s2[1]) + AW'(wg_s2[2]);
		span_c = SPW'(a_c) - (SPW'(b_c) <<< 1) + SPW'(c_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3    <= a_c;
			b_s3    <= b_c;
			c_s3    <= c_c;
			d_s3    <= d_c;
			e_s3    <= e_c;
			span_s3 <= span_c;
		end
	end

	logic signed [PW-1:0] ac_p, bb_p, be_p, cd_p, bd_p, ae_p;

	ptcp_wmul u_mul_ac (.clk(clk), .en(en), .x(a_s3), .y(c_s3), .p(ac_p));
	ptcp_wmul u_mul_bb (.clk(clk), .en(en), .x(b_s3), .y(b_s3), .p(bb_p));
	ptcp_wmul u_mul_be (.clk(clk), .en(en), .x(b_s3), .y(e_s3), .p(be_p));
	ptcp_wmul u_mul_cd (.clk(clk), .en(en), .x(c_s3), .y(d_s3), .p(cd_p));
	ptcp_wmul u_mul_bd (.clk(clk), .en(en), .x(b_s3), .y(d_s3), .p(bd_p));
	ptcp_wmul u_mul_ae (.clk(clk), .en(en), .x(a_s3), .y(e_s3), .p(ae_p));

	logic [DOTW-1:0]       dot_in, dot_out;
	logic signed [AW-1:0]  a_d, b_d, c_d, d_d, e_d;
	logic signed [SPW-1:0] span_d;

	assign dot_in = {span_s3, e_s3, d_s3, c_s3, b_s3, a_s3};

	ptcp_dly #(.W(DOTW), .N(DLY_DOT)) u_dly_dot (
		.clk(clk), .en(en), .din(dot_in), .dout(dot_out)
	);

	assign a_d    = dot_out[0*AW +: AW];
	assign b_d    = dot_out[1*AW +: AW];
	assign c_d    = dot_out[2*AW +: AW];
	assign d_d    = dot_out[3*AW +: AW];
	assign e_d    = dot_out[4*AW +: AW];
	assign span_d = dot_out[5*AW +: SPW];

	logic signed [SW-1:0] det_s8, sn_s8, tn_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			det_s8 <= SW'(ac_p) - SW'(bb_p);
			sn_s8  <= SW'(be_p) - SW'(cd_p);
			tn_s8  <= SW'(bd_p) - SW'(ae_p);
		end
	end

	logic signed [SW:0]    sum_st;
	logic signed [HW-1:0]  lo1, hi1, lo2, hi2;
	logic                  c0_s9, snn_s9, tnn_s9, dn_s9, lt1_s9, hle1_s9, lt2_s9, hle2_s9;
	logic signed [SPW-1:0] num1_s9, num2_s9, span_s9;
	logic signed [HW-1:0]  nd_s9, ne_s9;
	logic signed [AW-1:0]  a_s9, c_s9;
	logic signed [SW-1:0]  det_s9, sn_s9, tn_s9;

	always_comb begin
		sum_st = (SW+1)'(sn_s8) + (SW+1)'(tn_s8);
		lo1    = HW'(b_d) + HW'(d_d);
		hi1    = HW'(c_d) + HW'(e_d);
		lo2    = HW'(b_d) + HW'(e_d);
		hi2    = HW'(a_d) + HW'(d_d);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c0_s9   <= (SW+1)'(det_s8) >= sum_st;
			snn_s9  <= sn_s8[SW-1];
			tnn_s9  <= tn_s8[SW-1];
			dn_s9   <= d_d[AW-1];
			lt1_s9  <= lo1 < hi1;
			hle1_s9 <= hi1 <= 0;
			lt2_s9  <= lo2 < hi2;
			hle2_s9 <= hi2 <= 0;
			num1_s9 <= SPW'(hi1) - SPW'(lo1);
			num2_s9 <= SPW'(hi2) - SPW'(lo2);
			nd_s9   <= -HW'(d_d);
			ne_s9   <= -HW'(e_d);
			a_s9    <= a_d;
			c_s9    <= c_d;
			span_s9 <= span_d;
			det_s9  <= det_s8;
			sn_s9   <= sn_s8;
			tn_s9   <= tn_s8;
		end
	end

	logic signed [DW-1:0] numa_c, dena_c;
	sel_t                 ssel_c, tsel_c;
	logic signed [DW-1:0] numa_s10, dena_s10, numb_s10, denb_s10;
	sel_t                 ssel_s10, tsel_s10;

	always_comb begin
		numa_c = '0;
		dena_c = '0;
		ssel_c = SEL_ZERO;
		tsel_c = SEL_ZERO;
		if (c0_s9) begin
			if (snn_s9) begin
				if (tnn_s9 && dn_s9) begin
					numa_c = DW'(nd_s9);
					dena_c = DW'(a_s9);
					ssel_c = SEL_QA;
				end else begin
					numa_c = DW'(ne_s9);
					dena_c = DW'(c_s9);
					tsel_c = SEL_QA;
				end
			end else if (tnn_s9) begin
				numa_c = DW'(nd_s9);
				dena_c = DW'(a_s9);
				ssel_c = SEL_QA;
			end else begin
				numa_c = DW'(sn_s9);
				dena_c = DW'(det_s9);
				ssel_c = SEL_QA;
				tsel_c = SEL_QB;
			end
		end else if (snn_s9) begin
			if (lt1_s9) begin
				numa_c = DW'(num1_s9);
				dena_c = DW'(span_s9);
				ssel_c = SEL_QA;
				tsel_c = SEL_INV_QA;
			end else if (hle1_s9) begin
				tsel_c = SEL_ONE;
			end else begin
				numa_c = DW'(ne_s9);
				dena_c = DW'(c_s9);
				tsel_c = SEL_QA;
			end
		end else if (tnn_s9) begin
			if (lt2_s9) begin
				numa_c = DW'(num2_s9);
				dena_c = DW'(span_s9);
				tsel_c = SEL_QA;
				ssel_c = SEL_INV_QA;
			end else if (hle2_s9) begin
				ssel_c = SEL_ONE;
			end else begin
				numa_c = DW'(nd_s9);
				dena_c = DW'(a_s9);
				ssel_c = SEL_QA;
			end
		end else begin
			if (num1_s9 <= 0) begin
				tsel_c = SEL_ONE;
			end else begin
				numa_c = DW'(num1_s9);
				dena_c = DW'(span_s9);
				ssel_c = SEL_QA;
				tsel_c = SEL_INV_QA;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numa_s10 <= numa_c;
			dena_s10 <= dena_c;
			numb_s10 <= DW'(tn_s9);
			denb_s10 <= DW'(det_s9);
			ssel_s10 <= ssel_c;
			tsel_s10 <= tsel_c;
		end
	end

	logic [QW-1:0] qa, qb;

	ptcp_div u_div_a (.clk(clk), .en(en), .num(numa_s10), .den(dena_s10), .q(qa));
	ptcp_div u_div_b (.clk(clk), .en(en), .num(numb_s10), .den(denb_s10), .q(qb));

	logic [SELW-1:0] sel_in, sel_out;
	sel_t            ssel_d, tsel_d;

	assign sel_in = {tsel_s10, ssel_s10};

	ptcp_dly #(.W(SELW), .N(DLY_SEL)) u_dly_sel (
		.clk(clk), .en(en), .din(sel_in), .dout(sel_out)
	);

	assign ssel_d = sel_t'(sel_out[2:0]);
	assign tsel_d = sel_t'(sel_out[5:3]);

	function automatic logic [QW-1:0] pick(input sel_t sel, input logic [QW-1:0] xa,
			input logic [QW-1:0] xb);
		logic [QW-1:0] r;
		case (sel)
			SEL_ONE:    r = ONE_Q;
			SEL_QA:     r = xa;
			SEL_QB:     r = xb;
			SEL_INV_QA: r = ONE_Q - xa;
			default:    r = '0;
		endcase
		return r;
	endfunction

	logic [QW-1:0] su_s28, tu_s28;

	always_ff @(posedge clk) begin
		if (en) begin
			su_s28 <= pick(ssel_d, qa, qb);
			tu_s28 <= pick(tsel_d, qa, qb);
		end
	end

	logic [3*SIDEW-1:0]    side_in, side_out;
	logic signed [CW-1:0]  v0_d [3];
	logic signed [CW-1:0]  qp_d [3];
	logic signed [DXW-1:0] eu_d [3];
	logic signed [DXW-1:0] ew_d [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			side_in[SIDEW*i +: SIDEW] = {ew_s1[i], eu_s1[i], qp_s1[i], v0_s1[i]};
			v0_d[i] = side_out[SIDEW*i +: CW];
			qp_d[i] = side_out[SIDEW*i + CW +: CW];
			eu_d[i] = side_out[SIDEW*i + 2*CW +: DXW];
			ew_d[i] = side_out[SIDEW*i + 2*CW + DXW +: DXW];
		end
	end

	ptcp_dly #(.W(3*SIDEW), .N(DLY_SIDE)) u_dly_side (
		.clk(clk), .en(en), .din(side_in), .dout(side_out)
	);

	logic signed [OW-1:0] pe_s29 [3];
	logic signed [OW-1:0] pw_s29 [3];
	logic signed [CW-1:0] v0_s29 [3];
	logic signed [CW-1:0] qp_s29 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pe_s29[i] <= eu_d[i] * $signed({1'b0, su_s28});
				pw_s29[i] <= ew_d[i] * $signed({1'b0, tu_s28});
				v0_s29[i] <= v0_d[i];
				qp_s29[i] <= qp_d[i];
			end
		end
	end

	logic signed [FW-1:0]  off_c [3];
	logic signed [CXW-1:0] c_s30  [3];
	logic signed [CW-1:0]  qp_s30 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off_c[i] = FW'(pe_s29[i]) + FW'(pw_s29[i]) + ROUND_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s30[i]  <= CXW'(v0_s29[i]) + CXW'($signed(off_c[i][FW-1:FRAC]));
				qp_s30[i] <= qp_s29[i];
			end
		end
	end

	logic signed [CW-1:0]  cl_c   [3];
	logic signed [CW-1:0]  cl_s31 [3];
	logic signed [DXW-1:0] dv_s31 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (c_s30[i] > CXW'(COORD_MAX)) begin
				cl_c[i] = COORD_MAX;
			end else if (c_s30[i] < CXW'(COORD_MIN)) begin
				cl_c[i] = COORD_MIN;
			end else begin
				cl_c[i] = c_s30[i][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				cl_s31[i] <= cl_c[i];
				dv_s31[i] <= DXW'(cl_c[i]) - DXW'(qp_s30[i]);
			end
		end
	end

	logic [DXW-1:0]   mag_c  [3];
	logic [2*DXW-1:0] sq_s32 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = dv_s31[i][DXW-1] ? -dv_s31[i] : dv_s31[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s32[i] <= mag_c[i] * mag_c[i];
			end
		end
	end

	logic [SQW-1:0] tot_c;
	logic [RW-1:0]  n_s33;
	logic           over_s33;

	assign tot_c = SQW'(sq_s32[0]) + SQW'(sq_s32[1]) + SQW'(sq_s32[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s33    <= tot_c[RW-1:0];
			over_s33 <= |tot_c[SQW-1:RW];
		end
	end

	logic [ROOTW-1:0] root;

	ptcp_isqrt u_isqrt (.clk(clk), .en(en), .n(n_s33), .root(root));

	logic [3*CW-1:0] cl_in, cl_out;
	logic [0:0]      ov_out;

	assign cl_in = {cl_s31[2], cl_s31[1], cl_s31[0]};

	ptcp_dly #(.W(3*CW), .N(DLY_CL)) u_dly_cl (
		.clk(clk), .en(en), .din(cl_in), .dout(cl_out)
	);

	ptcp_dly #(.W(1), .N(DLY_OV)) u_dly_ov (
		.clk(clk), .en(en), .din(over_s33), .dout(ov_out)
	);

	logic [NOUT*CW-1:0] out_s66;

	always_ff @(posedge clk) begin
		if (en) begin
			out_s66 <= {(ov_out[0] ? {CW{1'b1}} : root), cl_out};
		end
	end

	assign m_tdata = out_s66;

endmodule
